// ===== hdl/spa_pkg.sv =====
// Package with shared constants, types and codes of the priority slot allocator.
`timescale 1ns / 1ps
package spa_pkg;

  localparam int unsigned SLOT_COUNT_DEF = 64;

  localparam int unsigned PRIO_W  = 8;
  localparam int unsigned TIME_W  = 16;
  localparam int unsigned INDEX_W = 6;
  localparam int unsigned ACT_W   = 7;
  localparam int unsigned DROP_W  = 16;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_TICK  = 1'b1;

  typedef struct packed {
    logic [PRIO_W-1:0] prio;
    logic [TIME_W-1:0] age;
    logic [TIME_W-1:0] life;
  } slot_word_t;

  localparam int unsigned WORD_W = $bits(slot_word_t);

  typedef struct packed {
    logic capture;
    logic rd_en;
    logic commit;
  } ctrl_cmd_t;

endpackage

// ===== hdl/spa_if.sv =====
// Channel interfaces for request items and result items.
`timescale 1ns / 1ps
interface spa_in_if import spa_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              operation;
  logic [PRIO_W-1:0] request_priority;
  logic [TIME_W-1:0] request_lifetime;
  logic [TIME_W-1:0] tick_amount;

  modport source (output valid, output operation, output request_priority,
                  output request_lifetime, output tick_amount, input ready);
  modport sink (input valid, input operation, input request_priority,
                input request_lifetime, input tick_amount, output ready);
endinterface

interface spa_out_if import spa_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [INDEX_W-1:0] slot_index;
  logic               granted;
  logic               evicted;
  logic [ACT_W-1:0]   active_count;
  logic [DROP_W-1:0]  dropped_total;

  modport source (output valid, output slot_index, output granted, output evicted,
                  output active_count, output dropped_total, input ready);
  modport sink (input valid, input slot_index, input granted, input evicted,
                input active_count, input dropped_total, output ready);
endinterface

// ===== hdl/spa_ram.sv =====
// Generic simple dual-port RAM with registered read data.
`timescale 1ns / 1ps
module spa_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hdl/spa_ctrl.sv =====
// Controller state machine that sequences the slot scan, commit and result hand-off.
`timescale 1ns / 1ps
module spa_ctrl import spa_pkg::*; #(
  parameter int unsigned SLOT_COUNT = SLOT_COUNT_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  output logic                          out_valid,
  input  logic                          out_ready,
  output ctrl_cmd_t                     cmd,
  output logic [$clog2(SLOT_COUNT)-1:0] rd_addr
);

  localparam int unsigned IDX_W = $clog2(SLOT_COUNT);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOT_COUNT - 1);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_SCAN   = 3'd1;
  localparam logic [2:0] ST_DRAIN  = 3'd2;
  localparam logic [2:0] ST_COMMIT = 3'd3;
  localparam logic [2:0] ST_OUT    = 3'd4;

  logic [2:0]       state_r, state_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;

  always_comb begin
    state_nxt   = state_r;
    idx_nxt     = idx_r;
    cmd         = '0;
    in_ready    = 1'b0;
    out_valid   = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          idx_nxt     = '0;
          state_nxt   = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.rd_en = 1'b1;
        if (idx_r == LAST_IDX) begin
          state_nxt = ST_DRAIN;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_COMMIT;
      end
      ST_COMMIT: begin
        cmd.commit = 1'b1;
        state_nxt  = ST_OUT;
      end
      ST_OUT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign rd_addr = idx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
    end
  end

endmodule

// ===== hdl/spa_dp.sv =====
// Datapath holding the slot store, busy marks, counters, scan trackers and result register.
`timescale 1ns / 1ps
module spa_dp import spa_pkg::*; #(
  parameter int unsigned SLOT_COUNT = SLOT_COUNT_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  ctrl_cmd_t                     cmd,
  input  logic [$clog2(SLOT_COUNT)-1:0] rd_addr,
  input  logic                          operation,
  input  logic [PRIO_W-1:0]             request_priority,
  input  logic [TIME_W-1:0]             request_lifetime,
  input  logic [TIME_W-1:0]             tick_amount,
  output logic [INDEX_W-1:0]            slot_index,
  output logic                          granted,
  output logic                          evicted,
  output logic [ACT_W-1:0]              active_count,
  output logic [DROP_W-1:0]             dropped_total
);

  localparam int unsigned IDX_W = $clog2(SLOT_COUNT);
  localparam int unsigned CNT_W = $clog2(SLOT_COUNT + 1);

  logic              op_r;
  logic [PRIO_W-1:0] prio_r;
  logic [TIME_W-1:0] life_r;
  logic [TIME_W-1:0] tick_r;

  logic              p_vld_r;
  logic [IDX_W-1:0]  p_idx_r;

  logic [SLOT_COUNT-1:0] busy_r;
  logic [CNT_W-1:0]      count_r, count_nxt;
  logic [DROP_W-1:0]     drop_r, drop_nxt;

  logic              free_found_r, free_found_nxt;
  logic [IDX_W-1:0]  free_idx_r, free_idx_nxt;
  logic              best_found_r, best_found_nxt;
  logic [IDX_W-1:0]  best_idx_r, best_idx_nxt;
  logic [PRIO_W-1:0] best_prio_r, best_prio_nxt;
  logic [TIME_W-1:0] best_age_r, best_age_nxt;

  logic [INDEX_W-1:0] out_idx_r;
  logic               out_grant_r;
  logic               out_evict_r;
  logic [ACT_W-1:0]   out_act_r;
  logic [DROP_W-1:0]  out_drop_r;

  logic [WORD_W-1:0] rd_data;
  logic [WORD_W-1:0] wr_data;
  logic [IDX_W-1:0]  wr_addr;
  logic              wr_en;
  slot_word_t        rd_word;
  slot_word_t        tick_word;
  slot_word_t        alloc_word;
  logic [TIME_W:0]   age_sum;
  logic [TIME_W-1:0] new_age;
  logic              cur_busy;
  logic              tick_stage;
  logic              alloc_stage;
  logic              expire;
  logic              candidate;
  logic              grant;
  logic              alloc_commit;
  logic [IDX_W-1:0]  win_idx;
  logic [IDX_W+INDEX_W-1:0] win_idx_ext;
  logic [CNT_W+ACT_W-1:0]   count_ext;

  spa_ram #(
    .WIDTH(WORD_W),
    .DEPTH(SLOT_COUNT)
  ) u_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_data),
    .re    (cmd.rd_en),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  always_comb begin
    rd_word     = slot_word_t'(rd_data);
    age_sum     = {1'b0, rd_word.age} + {1'b0, tick_r};
    new_age     = age_sum[TIME_W] ? '1 : age_sum[TIME_W-1:0];
    cur_busy    = busy_r[p_idx_r];
    tick_stage  = p_vld_r && (op_r == OP_TICK) && cur_busy;
    alloc_stage = p_vld_r && (op_r == OP_ALLOC);
    expire      = new_age >= rd_word.life;

    tick_word      = rd_word;
    tick_word.age  = new_age;
    alloc_word.prio = prio_r;
    alloc_word.age  = '0;
    alloc_word.life = life_r;

    grant        = free_found_r || best_found_r;
    win_idx      = free_found_r ? free_idx_r : best_idx_r;
    alloc_commit = cmd.commit && (op_r == OP_ALLOC) && grant;

    wr_en   = tick_stage || alloc_commit;
    wr_addr = cmd.commit ? win_idx : p_idx_r;
    wr_data = cmd.commit ? WORD_W'(alloc_word) : WORD_W'(tick_word);

    candidate = cur_busy && (rd_word.prio <= prio_r) &&
                (!best_found_r || (rd_word.prio < best_prio_r) ||
                 ((rd_word.prio == best_prio_r) && (rd_word.age > best_age_r)));
  end

  always_comb begin
    free_found_nxt = free_found_r;
    free_idx_nxt   = free_idx_r;
    best_found_nxt = best_found_r;
    best_idx_nxt   = best_idx_r;
    best_prio_nxt  = best_prio_r;
    best_age_nxt   = best_age_r;
    if (cmd.capture) begin
      free_found_nxt = 1'b0;
      best_found_nxt = 1'b0;
    end else if (alloc_stage) begin
      if (!cur_busy && !free_found_r) begin
        free_found_nxt = 1'b1;
        free_idx_nxt   = p_idx_r;
      end
      if (candidate) begin
        best_found_nxt = 1'b1;
        best_idx_nxt   = p_idx_r;
        best_prio_nxt  = rd_word.prio;
        best_age_nxt   = rd_word.age;
      end
    end
  end

  always_comb begin
    count_nxt = count_r;
    drop_nxt  = drop_r;
    if (tick_stage && expire) begin
      count_nxt = count_r - 1'b1;
    end else if (alloc_commit && free_found_r) begin
      count_nxt = count_r + 1'b1;
    end
    if (cmd.commit && (op_r == OP_ALLOC) && !grant && (drop_r != '1)) begin
      drop_nxt = drop_r + 1'b1;
    end
  end

  assign win_idx_ext = {{INDEX_W{1'b0}}, win_idx};
  assign count_ext   = {{ACT_W{1'b0}}, count_nxt};

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r   <= operation;
      prio_r <= request_priority;
      life_r <= request_lifetime;
      tick_r <= tick_amount;
    end
    p_idx_r      <= rd_addr;
    free_found_r <= free_found_nxt;
    free_idx_r   <= free_idx_nxt;
    best_found_r <= best_found_nxt;
    best_idx_r   <= best_idx_nxt;
    best_prio_r  <= best_prio_nxt;
    best_age_r   <= best_age_nxt;
    if (cmd.commit) begin
      out_idx_r   <= alloc_commit ? win_idx_ext[INDEX_W-1:0] : '0;
      out_grant_r <= alloc_commit;
      out_evict_r <= alloc_commit && !free_found_r;
      out_act_r   <= count_ext[ACT_W-1:0];
      out_drop_r  <= drop_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_vld_r <= 1'b0;
      busy_r  <= '0;
      count_r <= '0;
      drop_r  <= '0;
    end else begin
      p_vld_r <= cmd.rd_en;
      count_r <= count_nxt;
      drop_r  <= drop_nxt;
      if (tick_stage && expire) begin
        busy_r[p_idx_r] <= 1'b0;
      end else if (alloc_commit) begin
        busy_r[win_idx] <= 1'b1;
      end
    end
  end

  assign slot_index    = out_idx_r;
  assign granted       = out_grant_r;
  assign evicted       = out_evict_r;
  assign active_count  = out_act_r;
  assign dropped_total = out_drop_r;

endmodule

// ===== hdl/priority_slot_allocator_with_aging.sv =====
// Top level of the priority slot allocator with aging.
// Each accepted item runs through the states scan, drain and commit before its result is valid.
// A new item is accepted only after the result of the last one has been taken.
// The slot scan reads one entry of the slot RAM per cycle.
// Reset is synchronous and active low; it frees every slot and clears the drop count.
`timescale 1ns / 1ps
module priority_slot_allocator_with_aging import spa_pkg::*; #(
  parameter int unsigned SLOT_COUNT = SLOT_COUNT_DEF
) (
  input  logic    clk,
  input  logic    rst_n,
  spa_in_if.sink  in_ch,
  spa_out_if.source out_ch
);

  ctrl_cmd_t                     cmd;
  logic [$clog2(SLOT_COUNT)-1:0] rd_addr;

  spa_ctrl #(
    .SLOT_COUNT(SLOT_COUNT)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd),
    .rd_addr   (rd_addr)
  );

  spa_dp #(
    .SLOT_COUNT(SLOT_COUNT)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .rd_addr          (rd_addr),
    .operation        (in_ch.operation),
    .request_priority (in_ch.request_priority),
    .request_lifetime (in_ch.request_lifetime),
    .tick_amount      (in_ch.tick_amount),
    .slot_index       (out_ch.slot_index),
    .granted          (out_ch.granted),
    .evicted          (out_ch.evicted),
    .active_count     (out_ch.active_count),
    .dropped_total    (out_ch.dropped_total)
  );

endmodule

// ===== hdl/spa_chk.sv =====
// Port-level checker for the priority slot allocator, bound to the top level.
`timescale 1ns / 1ps
module spa_chk (
  input logic       clk,
  input logic       rst_n,
  spa_in_if.sink    in_ch,
  spa_out_if.source out_ch
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.ready) |=> out_ch.valid)
    else $error("Result item withdrawn before it was taken.");

  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> !in_ch.ready)
    else $error("New item offered while a result is still pending.");

  a_evict_grant: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.evicted) |-> out_ch.granted)
    else $error("Eviction reported without a granted slot.");

  a_no_grant_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.granted) |-> (out_ch.slot_index == '0))
    else $error("Slot index is not zero on a result without a grant.");

  a_result_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !out_ch.valid)
    else $error("Result appeared in the cycle after an item was accepted.");

endmodule

bind priority_slot_allocator_with_aging spa_chk u_spa_chk (
  .clk    (clk),
  .rst_n  (rst_n),
  .in_ch  (in_ch),
  .out_ch (out_ch)
);

// ===== tb/tb_top.sv =====
// Self-checking testbench of the priority slot allocator with aging.
`timescale 1ns / 1ps
module tb_top;
  import spa_pkg::*;

  localparam int unsigned SLOTS        = SLOT_COUNT_DEF;
  localparam int unsigned CYCLE_LIMIT  = 1000000;
  localparam int unsigned PHASE_ITEMS  = 208;
  localparam logic [TIME_W-1:0] TIME_MAX = '1;
  localparam logic [DROP_W-1:0] DROP_MAX = '1;

  typedef struct packed {
    logic              operation;
    logic [PRIO_W-1:0] prio;
    logic [TIME_W-1:0] life;
    logic [TIME_W-1:0] tick;
  } request_t;

  typedef struct packed {
    logic [INDEX_W-1:0] slot_index;
    logic               granted;
    logic               evicted;
    logic [ACT_W-1:0]   active_count;
    logic [DROP_W-1:0]  dropped_total;
  } grant_t;

  typedef struct packed {
    request_t req;
    logic     typed;
    grant_t   res;
  } row_t;

  logic        clk;
  logic        rst_n;
  int unsigned cycles = 0;
  int unsigned fail_count = 0;
  int unsigned idle_pct = 0;
  int unsigned stall_pct = 0;

  logic              pool_busy [SLOTS] = '{default: 1'b0};
  logic [PRIO_W-1:0] pool_prio [SLOTS];
  logic [TIME_W-1:0] pool_age  [SLOTS];
  logic [TIME_W-1:0] pool_life [SLOTS];
  logic [DROP_W-1:0] drop_count = '0;

  row_t   typed_notes [$];
  grant_t pending_grants [$];

  spa_in_if  in_ch ();
  spa_out_if out_ch ();

  priority_slot_allocator_with_aging #(.SLOT_COUNT(SLOTS)) u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  function automatic int unsigned pool_occupancy();
    int unsigned n;
    n = 0;
    for (int i = 0; i < SLOTS; i++) begin
      if (pool_busy[i]) n++;
    end
    return n;
  endfunction

  function automatic grant_t advance_pool(request_t r);
    grant_t      g;
    int          best;
    int unsigned sum;
    int unsigned held;
    g = '0;
    best = -1;
    if (r.operation == OP_TICK) begin
      for (int i = 0; i < SLOTS; i++) begin
        if (pool_busy[i]) begin
          sum = 32'(pool_age[i]) + 32'(r.tick);
          pool_age[i] = (sum > 32'(TIME_MAX)) ? TIME_MAX : sum[TIME_W-1:0];
          if (pool_age[i] >= pool_life[i]) pool_busy[i] = 1'b0;
        end
      end
    end else begin
      for (int i = 0; i < SLOTS; i++) begin
        if (!pool_busy[i] && best < 0) best = i;
      end
      if (best < 0) begin
        for (int i = 0; i < SLOTS; i++) begin
          if (pool_prio[i] <= r.prio &&
              (best < 0 || pool_prio[i] < pool_prio[best] ||
               (pool_prio[i] == pool_prio[best] && pool_age[i] > pool_age[best])))
            best = i;
        end
        g.evicted = (best >= 0);
      end
      if (best < 0) begin
        if (drop_count != DROP_MAX) drop_count = drop_count + 1'b1;
      end else begin
        pool_busy[best] = 1'b1;
        pool_prio[best] = r.prio;
        pool_age[best]  = '0;
        pool_life[best] = r.life;
        g.slot_index    = best[INDEX_W-1:0];
        g.granted       = 1'b1;
      end
    end
    held = pool_occupancy();
    g.active_count  = held[ACT_W-1:0];
    g.dropped_total = drop_count;
    return g;
  endfunction

  function automatic row_t mk_row(logic op, int unsigned prio, int unsigned life,
                                  int unsigned tick, int unsigned typed, int unsigned idx,
                                  int unsigned got, int unsigned ev, int unsigned act,
                                  int unsigned drops);
    row_t w;
    w.req.operation      = op;
    w.req.prio           = PRIO_W'(prio);
    w.req.life           = TIME_W'(life);
    w.req.tick           = TIME_W'(tick);
    w.typed              = (typed != 0);
    w.res.slot_index     = INDEX_W'(idx);
    w.res.granted        = (got != 0);
    w.res.evicted        = (ev != 0);
    w.res.active_count   = ACT_W'(act);
    w.res.dropped_total  = DROP_W'(drops);
    return w;
  endfunction

  // Most items fill the pool and then fight over it with small priorities,
  // so that evictions, ties and drops are frequent; a few are pure noise.
  function automatic request_t random_request();
    request_t    r;
    logic [31:0] v;
    int unsigned roll;
    roll = $urandom_range(99);
    v = $urandom;
    r.operation = OP_ALLOC;
    r.prio = v[PRIO_W-1:0];
    v = $urandom;
    r.life = v[TIME_W-1:0];
    v = $urandom;
    r.tick = v[TIME_W-1:0];
    if (roll < 8) begin
      v = $urandom;
      r.operation = v[0];
    end else if (pool_occupancy() < SLOTS) begin
      if (roll < 85) begin
        if ($urandom_range(99) < 75) begin
          v = $urandom_range(15);
          r.prio = v[PRIO_W-1:0];
        end
        if ($urandom_range(99) < 85) v = $urandom_range(65535, 3000);
        else v = $urandom_range(300);
        r.life = v[TIME_W-1:0];
      end else begin
        r.operation = OP_TICK;
        v = $urandom_range(15);
        r.tick = v[TIME_W-1:0];
      end
    end else begin
      if (roll < 78) begin
        if ($urandom_range(99) < 85) begin
          v = $urandom_range(15);
          r.prio = v[PRIO_W-1:0];
        end
      end else if (roll < 96) begin
        r.operation = OP_TICK;
        v = $urandom_range(40);
        r.tick = v[TIME_W-1:0];
      end else begin
        r.operation = OP_TICK;
        v = $urandom_range(65535, 2000);
        r.tick = v[TIME_W-1:0];
      end
    end
    return r;
  endfunction

  task automatic send_request(request_t r, logic typed, grant_t res);
    row_t note;
    while ($urandom_range(99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    note.req   = r;
    note.typed = typed;
    note.res   = res;
    typed_notes.push_back(note);
    in_ch.valid            <= 1'b1;
    in_ch.operation        <= r.operation;
    in_ch.request_priority <= r.prio;
    in_ch.request_lifetime <= r.life;
    in_ch.tick_amount      <= r.tick;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      fail_count++;
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin : accept_side
    request_t req;
    row_t     note;
    grant_t   predicted;
    if (rst_n && in_ch.valid && in_ch.ready) begin
      req.operation = in_ch.operation;
      req.prio      = in_ch.request_priority;
      req.life      = in_ch.request_lifetime;
      req.tick      = in_ch.tick_amount;
      predicted = advance_pool(req);
      note = typed_notes.pop_front();
      pending_grants.push_back(note.typed ? note.res : predicted);
    end
  end

  always @(posedge clk) begin : result_side
    grant_t got;
    grant_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.slot_index    = out_ch.slot_index;
      got.granted       = out_ch.granted;
      got.evicted       = out_ch.evicted;
      got.active_count  = out_ch.active_count;
      got.dropped_total = out_ch.dropped_total;
      if (pending_grants.size() == 0) begin
        fail_count++;
        $display("%0t: result item with none expected, got slot %0d granted %0b",
                 $time, got.slot_index, got.granted);
      end else begin
        want = pending_grants.pop_front();
        check_field("slot_index", 32'(want.slot_index), 32'(got.slot_index));
        check_field("granted", 32'(want.granted), 32'(got.granted));
        check_field("evicted", 32'(want.evicted), 32'(got.evicted));
        check_field("active_count", 32'(want.active_count), 32'(got.active_count));
        check_field("dropped_total", 32'(want.dropped_total), 32'(got.dropped_total));
      end
    end
  end

  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      out_ch.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  initial begin : stimulus
    row_t        rows [$];
    int unsigned idle_plan [4];
    int unsigned stall_plan [4];
    idle_plan  = '{0, 77, 0, 20};
    stall_plan = '{0, 0, 77, 20};
    rst_n                  = 1'b0;
    in_ch.valid            = 1'b0;
    in_ch.operation        = OP_ALLOC;
    in_ch.request_priority = '0;
    in_ch.request_lifetime = '0;
    in_ch.tick_amount      = '0;

    rows.push_back(mk_row(OP_TICK,  0,      0,      0,      1, 0, 0, 0, 0, 0));
    rows.push_back(mk_row(OP_ALLOC, 0,      0,      0,      1, 0, 1, 0, 1, 0));
    // A zero lifetime is freed by the next tick even when it adds nothing.
    rows.push_back(mk_row(OP_TICK,  0,      0,      0,      1, 0, 0, 0, 0, 0));
    rows.push_back(mk_row(OP_ALLOC, 255,    65535,  0,      1, 0, 1, 0, 1, 0));
    rows.push_back(mk_row(OP_ALLOC, 0,      1,      0,      1, 1, 1, 0, 2, 0));
    rows.push_back(mk_row(OP_TICK,  0,      0,      1,      1, 0, 0, 0, 1, 0));
    rows.push_back(mk_row(OP_ALLOC, 128,    65535,  0,      1, 1, 1, 0, 2, 0));
    // Ages saturate, which reaches the largest lifetime.
    rows.push_back(mk_row(OP_TICK,  0,      0,      65535,  1, 0, 0, 0, 0, 0));
    rows.push_back(mk_row(OP_ALLOC, 7,      100,    0,      1, 0, 1, 0, 1, 0));
    rows.push_back(mk_row(OP_ALLOC, 200,    65535,  0,      1, 1, 1, 0, 2, 0));
    rows.push_back(mk_row(OP_TICK,  0,      0,      99,     1, 0, 0, 0, 2, 0));
    rows.push_back(mk_row(OP_TICK,  0,      0,      1,      1, 0, 0, 0, 1, 0));
    rows.push_back(mk_row(OP_ALLOC, 1,      65534,  0,      1, 0, 1, 0, 2, 0));
    rows.push_back(mk_row(OP_TICK,  0,      0,      65535,  1, 0, 0, 0, 0, 0));
    rows.push_back(mk_row(OP_ALLOC, 'hAA,   'h5555, 'hFFFF, 1, 0, 1, 0, 1, 0));
    rows.push_back(mk_row(OP_ALLOC, 'h55,   'hAAAA, 0,      1, 1, 1, 0, 2, 0));
    rows.push_back(mk_row(OP_TICK,  'hFF,   'hFFFF, 'h5555, 1, 0, 0, 0, 1, 0));
    rows.push_back(mk_row(OP_TICK,  0,      0,      'hAAAA, 1, 0, 0, 0, 0, 0));
    rows.push_back(mk_row(OP_ALLOC, 9,      40,     0,      0, 0, 0, 0, 0, 0));
    rows.push_back(mk_row(OP_ALLOC, 3,      0,      0,      0, 0, 0, 0, 0, 0));
    rows.push_back(mk_row(OP_TICK,  0,      0,      7,      0, 0, 0, 0, 0, 0));
    rows.push_back(mk_row(OP_ALLOC, 200,    65535,  0,      0, 0, 0, 0, 0, 0));

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    foreach (rows[k]) send_request(rows[k].req, rows[k].typed, rows[k].res);

    for (int p = 0; p < 4; p++) begin
      idle_pct = idle_plan[p];
      stall_pct <= stall_plan[p];
      repeat (PHASE_ITEMS) send_request(random_request(), 1'b0, '0);
    end
    in_ch.valid <= 1'b0;

    while (typed_notes.size() != 0 || pending_grants.size() != 0) @(posedge clk);
    repeat (SLOTS + 8) @(posedge clk);

    if (fail_count == 0 && pending_grants.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
